// File: rtl/fhpp_pkg.sv
`timescale 1ns / 1ps

package fhpp_pkg;

   // command carried on the request tuser
   typedef enum logic {
      CMD_PACK   = 1'b0,
      CMD_UNPACK = 1'b1
   } cmd_type;

   // exponent bias difference between single (127) and half (15)
   localparam logic [7:0]  EXP_BIAS_DIFF      = 8'd112;
   localparam logic [7:0]  SGL_EXP_MAX        = 8'hFF;
   localparam logic [4:0]  HALF_EXP_MAX       = 5'h1F;

   // narrowing thresholds on the single exponent field
   localparam logic [7:0]  NARROW_EXP_OVF     = 8'd143;  // half exponent >= 31
   localparam logic [7:0]  NARROW_EXP_MAX_SUB = 8'd112;  // half exponent <= 0
   localparam logic [7:0]  NARROW_EXP_MIN_SUB = 8'd102;  // below this all bits shift out
   localparam logic [7:0]  SUB_SHIFT_BASE     = 8'd126;  // shift = 126 - exponent

   localparam logic [14:0] HALF_INF_MAG       = 15'h7C00;
   localparam logic [15:0] HALF_NAN           = 16'hFE00;
   localparam logic [30:0] SGL_INF_MAG        = 31'h7F800000;
   localparam logic [31:0] SGL_NAN            = 32'hFFC00000;

endpackage

// File: rtl/fhpp_narrow.sv
`timescale 1ns / 1ps

module fhpp_narrow
   import fhpp_pkg::*;
(
   input  logic [31:0] sgl,
   output logic [15:0] half
);

   logic        sign;
   logic [7:0]  expo;
   logic [22:0] mant;
   logic [23:0] mant_full;
   logic [7:0]  sh_full;
   logic [4:0]  sub_sh;
   logic [23:0] sub_shifted;
   logic [23:0] sub_rnd_vec;
   logic [10:0] sub_hm;
   logic [7:0]  hexp_full;
   logic [15:0] norm;

   assign sign      = sgl[31];
   assign expo      = sgl[30:23];
   assign mant      = sgl[22:0];
   assign mant_full = {1'b1, mant};

   // denormal result: shift 14..24 with hidden bit restored, round on first dropped bit
   assign sh_full     = SUB_SHIFT_BASE - expo;
   assign sub_sh      = sh_full[4:0];
   assign sub_shifted = mant_full >> sub_sh;
   assign sub_rnd_vec = mant_full >> (sub_sh - 5'd1);
   assign sub_hm      = sub_shifted[10:0] + {10'd0, sub_rnd_vec[0]};

   // normal result: carry may ripple into the exponent
   assign hexp_full = expo - EXP_BIAS_DIFF;
   assign norm      = {sign, hexp_full[4:0], mant[22:13]} + {15'd0, mant[12]};

   always_comb begin
      if (expo == 8'd0) begin
         half = {sign, 15'd0};
      end else if (expo == SGL_EXP_MAX) begin
         half = (mant == 23'd0) ? {sign, HALF_INF_MAG} : HALF_NAN;
      end else if (expo >= NARROW_EXP_OVF) begin
         half = {sign, HALF_INF_MAG};
      end else if (expo < NARROW_EXP_MIN_SUB) begin
         half = {sign, 15'd0};
      end else if (expo <= NARROW_EXP_MAX_SUB) begin
         half = {sign, 4'd0, sub_hm};
      end else begin
         half = norm;
      end
   end

endmodule

// File: rtl/fhpp_widen.sv
`timescale 1ns / 1ps

module fhpp_widen
   import fhpp_pkg::*;
(
   input  logic [15:0] half,
   output logic [31:0] sgl
);

   logic        sign;
   logic [4:0]  expo;
   logic [9:0]  mant;
   logic [3:0]  lz;
   logic [10:0] den_shifted;
   logic [7:0]  den_exp;
   logic [7:0]  norm_exp;

   assign sign = half[15];
   assign expo = half[14:10];
   assign mant = half[9:0];

   // leading-zero count of the 10-bit fraction
   always_comb begin
      lz = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (mant[i]) begin
            lz = 4'(9 - i);
         end
      end
   end

   // leading one lands on bit 10 and is dropped as the hidden bit
   assign den_shifted = {mant, 1'b0} << lz;
   assign den_exp     = EXP_BIAS_DIFF - {4'd0, lz};
   assign norm_exp    = {3'd0, expo} + EXP_BIAS_DIFF;

   always_comb begin
      if (half[14:0] == 15'd0) begin
         sgl = {sign, 31'd0};
      end else if (expo == 5'd0) begin
         sgl = {sign, den_exp, den_shifted[9:0], 13'd0};
      end else if (expo == HALF_EXP_MAX) begin
         sgl = (mant == 10'd0) ? {sign, SGL_INF_MAG} : SGL_NAN;
      end else begin
         sgl = {sign, norm_exp, mant, 13'd0};
      end
   end

endmodule

// File: rtl/float_half_pair_pack_unpack_top.sv
`timescale 1ns / 1ps

// Single/half precision pair converter. tuser = 0 (pack): the two singles in
// req_tdata are narrowed to halves and rsp_tdata[31:0] carries the first half in
// bits 31:16 and the second in bits 15:0, upper word zero. Narrowing rounds up
// when the first dropped bit is set (ties away from zero), flushes single
// denormals to signed zero, saturates overflow to infinity, produces half
// denormals on underflow and maps every NaN to 0xFE00. tuser = 1 (unpack): the
// halves in req_tdata[31:16] and [15:0] are widened exactly to singles in
// rsp_tdata[31:0] and [63:32]; half denormals are normalized, NaN becomes
// 0xFFC00000, req_tdata[63:32] is ignored. The path runs through an input register,
// conversion logic and a result register; one item per cycle is sustained
// while rsp_tready holds, and a stalled result still lets one more item enter.

module float_half_pair_pack_unpack_top
   import fhpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // word_a[31:0], word_b[63:32]
   input  logic [0:0]  req_tuser,   // cmd[0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // out_a[31:0], out_b[63:32]
);

   // input stage
   logic        s1_valid_ff;
   logic        s1_valid_in;
   cmd_type     s1_cmd_ff;
   logic [31:0] s1_word_a_ff;
   logic [31:0] s1_word_b_ff;

   // result stage
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [63:0] rsp_data_ff;
   logic [63:0] rsp_data_in;

   logic        out_free;
   logic        s1_adv;
   logic        req_take;

   logic [15:0] half_a;
   logic [15:0] half_b;
   logic [31:0] wide_a;
   logic [31:0] wide_b;

   // result register frees when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff    <= cmd_type'(req_tuser[0]);
         s1_word_a_ff <= req_tdata[31:0];
         s1_word_b_ff <= req_tdata[63:32];
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // conversion datapath
   fhpp_narrow u_narrow_a (.sgl(s1_word_a_ff),        .half(half_a));
   fhpp_narrow u_narrow_b (.sgl(s1_word_b_ff),        .half(half_b));
   fhpp_widen  u_widen_a  (.half(s1_word_a_ff[31:16]), .sgl(wide_a));
   fhpp_widen  u_widen_b  (.half(s1_word_a_ff[15:0]),  .sgl(wide_b));

   always_comb begin
      case (s1_cmd_ff)
         CMD_PACK: begin
            rsp_data_in = {32'd0, half_a, half_b};
         end
         CMD_UNPACK: begin
            rsp_data_in = {wide_b, wide_a};
         end
         default: begin
            rsp_data_in = {32'd0, half_a, half_b};
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // empty input stage must never back-pressure
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("req_tready low with empty input stage");

   // a stalled item stays in the input stage
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff)
      else $error("input stage item dropped while stalled");

   // an advancing item shows up as a result
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_tvalid)
      else $error("advanced item missing at result");

   // pack results carry a zero upper word
   a_pack_upper_zero: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_cmd_ff == CMD_PACK |=> rsp_tdata[63:32] == 32'd0)
      else $error("pack result has nonzero upper word");
`endif

endmodule
